// ===== hdl/r2fft_pkg.sv =====
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared constants, types and the twiddle table of the radix-2 FFT.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int LOG_MAX     = 10;
  localparam int SAMPLE_BITS = 16;
  localparam int DATA_BITS   = 27;
  localparam int TW_BITS     = 17;
  localparam int TW_DEPTH    = MAX_POINTS / 2;
  localparam int TW_AW       = LOG_MAX - 1;
  localparam int ANGLE_GRID  = 16384;
  localparam logic [63:0] STEP_Q40 = 64'd421657428;
  localparam logic [63:0] ONE_Q30  = 64'd1073741824;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam int CosDiv[8] = '{2, 12, 30, 56, 90, 132, 182, 240};
  localparam int SinDiv[8] = '{6, 20, 42, 72, 110, 156, 210, 272};

  typedef enum logic [1:0] {
    WSEL_SAMPLE,
    WSEL_SUM,
    WSEL_DIFF
  } wsel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_BF_RA,
    ST_BF_RB,
    ST_BF_MUL,
    ST_BF_SUM,
    ST_BF_WA,
    ST_BF_WB
  } state_e;

  typedef struct packed {
    logic [LOG_MAX-1:0] raddr;
    logic               we;
    logic [LOG_MAX-1:0] waddr;
    wsel_e              wsel;
    logic [TW_AW-1:0]   tw_idx;
    logic               cap_a;
    logic               mul_en;
    logic               sum_en;
    logic               out_load;
    logic               out_zero;
    logic [LOG_MAX-1:0] out_index;
    logic               out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  function automatic logic [63:0] q30_to_q15(input logic [63:0] v);
    logic [63:0] w;
    w = v[63] ? 64'd0 : v;
    return (w + 64'd16384) >> 15;
  endfunction

  function automatic logic [2*TW_BITS-1:0] tw_entry(input int k);
    logic [63:0] p, x, x2, tc, ts, sc, ss, c, s, t;
    logic        neg, swap;
    p    = 64'(k) * 64'(ANGLE_GRID / MAX_POINTS);
    neg  = 1'b0;
    swap = 1'b0;
    if (p > 64'(ANGLE_GRID / 4)) begin
      p   = 64'(ANGLE_GRID / 2) - p;
      neg = 1'b1;
    end
    if (p > 64'(ANGLE_GRID / 8)) begin
      p    = 64'(ANGLE_GRID / 4) - p;
      swap = 1'b1;
    end
    x  = (p * STEP_Q40 + 64'd512) >> 10;
    x2 = (x * x) >> 30;
    tc = ONE_Q30;
    ts = x;
    sc = ONE_Q30;
    ss = x;
    for (int n = 1; n <= 8; n++) begin
      tc = ((tc * x2) >> 30) / 64'(CosDiv[n-1]);
      ts = ((ts * x2) >> 30) / 64'(SinDiv[n-1]);
      if (n % 2 == 1) begin
        sc = sc - tc;
        ss = ss - ts;
      end else begin
        sc = sc + tc;
        ss = ss + ts;
      end
    end
    c = q30_to_q15(sc);
    s = q30_to_q15(ss);
    if (swap) begin
      t = c;
      c = s;
      s = t;
    end
    if (neg) begin
      c = -c;
    end
    return {c[TW_BITS-1:0], s[TW_BITS-1:0]};
  endfunction

  typedef logic [2*TW_BITS-1:0] tw_table_t [TW_DEPTH];

  function automatic tw_table_t build_table();
    tw_table_t tab;
    for (int k = 0; k < TW_DEPTH; k++) begin
      tab[k] = tw_entry(k);
    end
    return tab;
  endfunction

  localparam tw_table_t TW_TABLE = build_table();

endpackage

// ===== hdl/r2fft_ram.sv =====
// ----------------------------------------------------------------------------
// r2fft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module r2fft_ram #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/r2fft_ctrl.sv =====
// ----------------------------------------------------------------------------
// r2fft_ctrl
// Sequencer: load addressing, butterfly schedule and bin readout.
// ----------------------------------------------------------------------------
module r2fft_ctrl
  import r2fft_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       in_command_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o,
  output logic       busy_o,
  output logic       have_result_o
);

  state_e             state_q, state_d;
  logic [3:0]         log2_q, log2_d;
  logic [LOG_MAX-1:0] load_cnt_q, load_cnt_d;
  logic [LOG_MAX-1:0] rd_cnt_q, rd_cnt_d;
  logic [3:0]         stage_q, stage_d;
  logic [TW_AW-1:0]   bf_q, bf_d;
  logic               have_q, have_d;

  logic [3:0]         len_log2;
  logic [LOG_MAX-1:0] mask;
  logic [LOG_MAX-1:0] rev;
  logic [LOG_MAX-1:0] load_addr;
  logic [LOG_MAX-1:0] half;
  logic [LOG_MAX-1:0] jpart;
  logic [LOG_MAX-1:0] addr_a;
  logic [LOG_MAX-1:0] addr_b;
  logic [LOG_MAX-1:0] next_load;
  logic               in_acc;
  logic               cfg_acc;

  always_comb begin
    if (log2_q == 4'd0) begin
      len_log2 = 4'd1;
    end else if (log2_q > 4'(LOG_MAX)) begin
      len_log2 = 4'(LOG_MAX);
    end else begin
      len_log2 = log2_q;
    end
  end

  assign mask = LOG_MAX'((LOG_MAX+1)'(1) << len_log2) - LOG_MAX'(1);

  always_comb begin
    for (int i = 0; i < LOG_MAX; i++) begin
      rev[i] = load_cnt_q[LOG_MAX-1-i];
    end
  end

  assign load_addr = rev >> (4'(LOG_MAX) - len_log2);
  assign next_load = (load_cnt_q + LOG_MAX'(1)) & mask;
  assign half      = LOG_MAX'(1) << stage_q;
  assign jpart     = LOG_MAX'(bf_q) & (half - LOG_MAX'(1));
  assign addr_a    = ((LOG_MAX'(bf_q) >> stage_q) << (stage_q + 4'd1)) | jpart;
  assign addr_b    = addr_a | half;

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = in_valid_i && in_ready_o;
  assign busy_o      = (state_q != ST_IDLE) && (state_q != ST_READ);
  assign have_result_o = have_q;

  always_comb begin
    state_d    = state_q;
    log2_d     = log2_q;
    load_cnt_d = load_cnt_q;
    rd_cnt_d   = rd_cnt_q;
    stage_d    = stage_q;
    bf_d       = bf_q;
    have_d     = have_q;

    cmd_o           = '0;
    cmd_o.wsel      = WSEL_SAMPLE;
    cmd_o.raddr     = rd_cnt_q;
    cmd_o.waddr     = addr_a;
    cmd_o.tw_idx    = TW_AW'(jpart << (4'(TW_AW) - stage_q));
    cmd_o.out_index = have_q ? rd_cnt_q : '0;
    cmd_o.out_last  = have_q && (rd_cnt_q == mask);
    cmd_o.out_zero  = !have_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_acc) begin
          log2_d     = cfg_data_i;
          load_cnt_d = '0;
          rd_cnt_d   = '0;
          have_d     = 1'b0;
        end else if (in_acc && (in_command_i == CMD_LOAD)) begin
          cmd_o.we    = 1'b1;
          cmd_o.waddr = load_addr;
          cmd_o.wsel  = WSEL_SAMPLE;
          have_d      = 1'b0;
          rd_cnt_d    = '0;
          load_cnt_d  = next_load;
          if (next_load == '0) begin
            stage_d = '0;
            bf_d    = '0;
            state_d = ST_BF_RA;
          end
        end else if (in_acc) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (have_q) begin
            rd_cnt_d = (rd_cnt_q + LOG_MAX'(1)) & mask;
          end
          state_d = ST_IDLE;
        end
      end
      ST_BF_RA: begin
        cmd_o.raddr = addr_a;
        state_d     = ST_BF_RB;
      end
      ST_BF_RB: begin
        cmd_o.raddr = addr_b;
        cmd_o.cap_a = 1'b1;
        state_d     = ST_BF_MUL;
      end
      ST_BF_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_BF_SUM;
      end
      ST_BF_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = ST_BF_WA;
      end
      ST_BF_WA: begin
        cmd_o.we    = 1'b1;
        cmd_o.waddr = addr_a;
        cmd_o.wsel  = WSEL_SUM;
        state_d     = ST_BF_WB;
      end
      ST_BF_WB: begin
        cmd_o.we    = 1'b1;
        cmd_o.waddr = addr_b;
        cmd_o.wsel  = WSEL_DIFF;
        state_d     = ST_BF_RA;
        if (bf_q == TW_AW'(mask >> 1)) begin
          bf_d = '0;
          if (stage_q == len_log2 - 4'd1) begin
            have_d   = 1'b1;
            rd_cnt_d = '0;
            state_d  = ST_IDLE;
          end else begin
            stage_d = stage_q + 4'd1;
          end
        end else begin
          bf_d = bf_q + TW_AW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      log2_q     <= 4'd10;
      load_cnt_q <= '0;
      rd_cnt_q   <= '0;
      stage_q    <= '0;
      bf_q       <= '0;
      have_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      log2_q     <= log2_d;
      load_cnt_q <= load_cnt_d;
      rd_cnt_q   <= rd_cnt_d;
      stage_q    <= stage_d;
      bf_q       <= bf_d;
      have_q     <= have_d;
    end
  end

endmodule

// ===== hdl/r2fft_dp.sv =====
// ----------------------------------------------------------------------------
// r2fft_dp
// Datapath: point store, twiddle ROM, butterfly arithmetic, output register.
// ----------------------------------------------------------------------------
module r2fft_dp
  import r2fft_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ctrl_cmd_t                     cmd_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_re_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_im_i,
  input  logic                          have_result_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [DATA_BITS-1:0]   bin_re_o,
  output logic signed [DATA_BITS-1:0]   bin_im_o,
  output logic [LOG_MAX-1:0]            bin_index_o,
  output logic                          last_bin_o,
  output logic                          frame_ready_o,
  output dp_status_t                    status_o
);

  localparam int PW = TW_BITS + DATA_BITS;

  logic [2*DATA_BITS-1:0]      wdata;
  logic [2*DATA_BITS-1:0]      rdata;
  logic signed [DATA_BITS-1:0] rd_re, rd_im;
  logic [2*TW_BITS-1:0]        tw_q;
  logic signed [TW_BITS-1:0]   tw_c, tw_s;
  logic signed [DATA_BITS-1:0] a_re_q, a_im_q;
  logic signed [PW-1:0]        p_cr_q, p_si_q, p_ci_q, p_sr_q;
  logic signed [PW:0]          sum_re, sum_im;
  logic signed [PW:0]          rnd_re, rnd_im;
  logic signed [DATA_BITS-1:0] t_re_q, t_im_q;
  logic signed [DATA_BITS-1:0] w_re, w_im;
  logic                        out_valid_q;
  logic signed [DATA_BITS-1:0] out_re_q, out_im_q;
  logic [LOG_MAX-1:0]          out_idx_q;
  logic                        out_last_q, out_fr_q;

  r2fft_ram #(
    .WIDTH(2 * DATA_BITS),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.we),
    .waddr_i(cmd_i.waddr),
    .wdata_i(wdata),
    .raddr_i(cmd_i.raddr),
    .rdata_o(rdata)
  );

  assign rd_re = rdata[DATA_BITS-1:0];
  assign rd_im = rdata[2*DATA_BITS-1:DATA_BITS];
  assign tw_c  = tw_q[2*TW_BITS-1:TW_BITS];
  assign tw_s  = tw_q[TW_BITS-1:0];

  always_ff @(posedge clk_i) begin
    tw_q <= TW_TABLE[cmd_i.tw_idx];
    if (cmd_i.cap_a) begin
      a_re_q <= rd_re;
      a_im_q <= rd_im;
    end
    if (cmd_i.mul_en) begin
      p_cr_q <= PW'(tw_c * rd_re);
      p_si_q <= PW'(tw_s * rd_im);
      p_ci_q <= PW'(tw_c * rd_im);
      p_sr_q <= PW'(tw_s * rd_re);
    end
    if (cmd_i.sum_en) begin
      t_re_q <= DATA_BITS'(rnd_re >>> 15);
      t_im_q <= DATA_BITS'(rnd_im >>> 15);
    end
  end

  assign sum_re = (PW+1)'(p_cr_q) + (PW+1)'(p_si_q);
  assign sum_im = (PW+1)'(p_ci_q) - (PW+1)'(p_sr_q);
  assign rnd_re = sum_re + (PW+1)'(16384);
  assign rnd_im = sum_im + (PW+1)'(16384);

  always_comb begin
    unique case (cmd_i.wsel)
      WSEL_SUM: begin
        w_re = a_re_q + t_re_q;
        w_im = a_im_q + t_im_q;
      end
      WSEL_DIFF: begin
        w_re = a_re_q - t_re_q;
        w_im = a_im_q - t_im_q;
      end
      default: begin
        w_re = DATA_BITS'(sample_re_i);
        w_im = DATA_BITS'(sample_im_i);
      end
    endcase
  end

  assign wdata = {w_im, w_re};

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_re_q   <= cmd_i.out_zero ? '0 : rd_re;
      out_im_q   <= cmd_i.out_zero ? '0 : rd_im;
      out_idx_q  <= cmd_i.out_index;
      out_last_q <= cmd_i.out_last;
      out_fr_q   <= have_result_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bin_re_o      = out_re_q;
  assign bin_im_o      = out_im_q;
  assign bin_index_o   = out_idx_q;
  assign last_bin_o    = out_last_q;
  assign frame_ready_o = out_fr_q;

endmodule

// ===== hdl/radix2_fft_in_place.sv =====
// Radix-2 decimation-in-time FFT over frames of 2^log2_size points (2 to 1024).
// A load beat (tuser 0) stores one sample at its bit-reversed address;
// the load that completes a frame starts the transform, which runs one
// butterfly at a time through the point RAM with its one read and one
// write port (read a, read b, multiply, round, write a, write b); no beat
// is accepted until the frame is done. A read beat (tuser 1) waits for
// the registered RAM read and a free output register, and returns the
// next bin in natural order with its index, wrapping after the last, or
// a zero bin while no frame is complete.
// Writing log2_size restarts the frame. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
// radix2_fft_in_place
// Top level: stream ports, sequencer and butterfly datapath.
// ----------------------------------------------------------------------------
module radix2_fft_in_place
  import r2fft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,       // log2_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,     // sample_re[15:0], sample_im[31:16]
  input  logic        s_axis_tuser,     // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,     // bin_re[26:0], bin_im[53:27], bin_index[63:54]
  output logic        m_axis_tlast,     // last_bin
  output logic        m_axis_tuser      // frame_ready
);

  ctrl_cmd_t                   cmd;
  dp_status_t                  status;
  logic                        busy;
  logic                        have_result;
  logic signed [DATA_BITS-1:0] bin_re, bin_im;
  logic [LOG_MAX-1:0]          bin_index;

  r2fft_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_command_i (s_axis_tuser),
    .status_i     (status),
    .cmd_o        (cmd),
    .busy_o       (busy),
    .have_result_o(have_result)
  );

  r2fft_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sample_re_i  (s_axis_tdata[15:0]),
    .sample_im_i  (s_axis_tdata[31:16]),
    .have_result_i(have_result),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .bin_re_o     (bin_re),
    .bin_im_o     (bin_im),
    .bin_index_o  (bin_index),
    .last_bin_o   (m_axis_tlast),
    .frame_ready_o(m_axis_tuser),
    .status_o     (status)
  );

  assign m_axis_tdata = {bin_index, bin_im, bin_re};

  a_no_accept_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready && !cfg_ready_o)
    else $error("beat accepted during transform");

  a_last_needs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("last bin flagged without a frame");

  a_empty_bin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 64'd0)
    else $error("bin without a frame is not zero");

  a_no_write_while_reading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !cmd.we)
    else $error("store written while a bin is read out");

endmodule

// ===== tb/sv/radix2_fft_in_place_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix2_fft_in_place_checker
// Watches the configuration, sample and bin channels of the FFT. It keeps
// its own frame store and twiddle table, runs the butterflies when a frame
// completes, and compares every returned bin with the oldest predicted bin.
// ----------------------------------------------------------------------------
module radix2_fft_in_place_checker
  import r2fft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,     // sample_re[15:0], sample_im[31:16]
  input  logic        s_axis_tuser,     // command
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,     // bin_re[26:0], bin_im[53:27], bin_index[63:54]
  input  logic        m_axis_tlast,     // last_bin
  input  logic        m_axis_tuser,     // frame_ready
  output int          mismatch_count,
  output int          bins_outstanding
);

  typedef struct packed {
    logic [DATA_BITS-1:0] re;
    logic [DATA_BITS-1:0] im;
    logic [LOG_MAX-1:0]   idx;
    logic                 last;
    logic                 held;
  } bin_t;

  bin_t        bin_queue[$];
  longint      point_re[MAX_POINTS];
  longint      point_im[MAX_POINTS];
  longint      cos_q15[MAX_POINTS/2];
  longint      sin_q15[MAX_POINTS/2];
  logic [3:0]  size_reg;
  int unsigned fill_pos;
  int unsigned read_pos;
  logic        frame_done;
  int          err_cnt = 0;

  assign mismatch_count = err_cnt;

  function automatic longint to_q15(input longint unsigned v);
    longint sv;
    sv = longint'(v);
    if (sv < 0) begin
      sv = 0;
    end
    return (sv + 16384) >>> 15;
  endfunction

  function automatic void make_twiddles();
    longint unsigned p, x, x2, tc, ts, sc, ss;
    longint          c, s, t;
    logic            neg, swap;
    for (int k = 0; k < MAX_POINTS/2; k++) begin
      p    = k * (16384 / MAX_POINTS);
      neg  = 1'b0;
      swap = 1'b0;
      if (p > 4096) begin
        p   = 8192 - p;
        neg = 1'b1;
      end
      if (p > 2048) begin
        p    = 4096 - p;
        swap = 1'b1;
      end
      x  = (p * 64'd421657428 + 64'd512) >> 10;
      x2 = (x * x) >> 30;
      tc = 64'd1073741824;
      ts = x;
      sc = tc;
      ss = x;
      for (int n = 1; n <= 8; n++) begin
        tc = ((tc * x2) >> 30) / ((2 * n - 1) * (2 * n));
        ts = ((ts * x2) >> 30) / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sc = sc - tc;
          ss = ss - ts;
        end else begin
          sc = sc + tc;
          ss = ss + ts;
        end
      end
      c = to_q15(sc);
      s = to_q15(ss);
      if (swap) begin
        t = c;
        c = s;
        s = t;
      end
      cos_q15[k] = neg ? -c : c;
      sin_q15[k] = s;
    end
  endfunction

  function automatic int frame_bits();
    int l;
    l = size_reg;
    if (l < 1) begin
      l = 1;
    end
    if (l > LOG_MAX) begin
      l = LOG_MAX;
    end
    return l;
  endfunction

  function automatic int unsigned rev_bits(input int unsigned v, input int bits);
    int unsigned r;
    r = 0;
    for (int i = 0; i < bits; i++) begin
      r |= ((v >> i) & 1) << (bits - 1 - i);
    end
    return r;
  endfunction

  function automatic void butterflies(input int l);
    int     n, stride, a, b, ti;
    longint tr, tm;
    n = 1 << l;
    for (int half = 1; half < n; half *= 2) begin
      stride = MAX_POINTS / (half * 2);
      for (int base = 0; base < n; base += half * 2) begin
        for (int j = 0; j < half; j++) begin
          a  = base + j;
          b  = a + half;
          ti = (j * stride) % (MAX_POINTS / 2);
          tr = (cos_q15[ti] * point_re[b] + sin_q15[ti] * point_im[b] + 16384) >>> 15;
          tm = (cos_q15[ti] * point_im[b] - sin_q15[ti] * point_re[b] + 16384) >>> 15;
          point_re[b] = point_re[a] - tr;
          point_im[b] = point_im[a] - tm;
          point_re[a] = point_re[a] + tr;
          point_im[a] = point_im[a] + tm;
        end
      end
    end
  endfunction

  function automatic void take_beat(input logic cmd, input logic [31:0] d);
    int          l, n;
    int unsigned addr;
    bin_t        exp_bin;
    l = frame_bits();
    n = 1 << l;
    if (cmd == CMD_LOAD) begin
      addr           = rev_bits(fill_pos % n, l);
      frame_done     = 1'b0;
      read_pos       = 0;
      point_re[addr] = longint'(signed'(d[15:0]));
      point_im[addr] = longint'(signed'(d[31:16]));
      fill_pos       = (fill_pos + 1) % n;
      if (fill_pos == 0) begin
        butterflies(l);
        frame_done = 1'b1;
      end
    end else if (!frame_done) begin
      exp_bin = '0;
      bin_queue.insert(bin_queue.size(), exp_bin);
    end else begin
      exp_bin.re   = point_re[read_pos][DATA_BITS-1:0];
      exp_bin.im   = point_im[read_pos][DATA_BITS-1:0];
      exp_bin.idx  = read_pos[LOG_MAX-1:0];
      exp_bin.last = (read_pos == n - 1);
      exp_bin.held = 1'b1;
      bin_queue.insert(bin_queue.size(), exp_bin);
      read_pos = (read_pos + 1) % n;
    end
  endfunction

  initial begin
    make_twiddles();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    bin_t got, exp_bin;
    if (!rst_ni) begin
      size_reg   = 4'd10;
      fill_pos   = 0;
      read_pos   = 0;
      frame_done = 1'b0;
      bin_queue.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        size_reg   = cfg_data_i;
        fill_pos   = 0;
        read_pos   = 0;
        frame_done = 1'b0;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        take_beat(s_axis_tuser, s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[26:0], m_axis_tdata[53:27], m_axis_tdata[63:54],
               m_axis_tlast, m_axis_tuser};
        if (bin_queue.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("Unexpected bin beat: re=%0d im=%0d idx=%0d last=%b ready=%b",
                     signed'(got.re), signed'(got.im), got.idx, got.last, got.held);
          end
        end else begin
          exp_bin = bin_queue.pop_front();
          if (got !== exp_bin) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("Bin mismatch: expected re=%0d im=%0d idx=%0d last=%b ready=%b",
                       signed'(exp_bin.re), signed'(exp_bin.im), exp_bin.idx,
                       exp_bin.last, exp_bin.held);
              $display("              actual   re=%0d im=%0d idx=%0d last=%b ready=%b",
                       signed'(got.re), signed'(got.im), got.idx, got.last, got.held);
            end
          end
        end
      end
    end
    bins_outstanding = bin_queue.size();
  end

endmodule

// ===== tb/sv/radix2_fft_in_place_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix2_fft_in_place_tb
// Drives sample and read beats into the FFT under several transform sizes
// and idle patterns, including a long output stall, and reports the verdict
// from the failure count and the outstanding bins of the checker.
// ----------------------------------------------------------------------------
module radix2_fft_in_place_tb;
  import r2fft_pkg::*;

  localparam int PHASE_BEATS = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;       // sample_re[15:0], sample_im[31:16]
  logic        s_axis_tuser = 1'b0;     // command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;            // bin_re[26:0], bin_im[53:27], bin_index[63:54]
  logic        m_axis_tlast;            // last_bin
  logic        m_axis_tuser;            // frame_ready

  int mismatch_count;
  int bins_outstanding;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cycles = 0;
  int size_bits = LOG_MAX;

  always #10 clk_i = ~clk_i;

  radix2_fft_in_place uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  radix2_fft_in_place_checker fft_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .m_axis_tuser     (m_axis_tuser),
    .mismatch_count   (mismatch_count),
    .bins_outstanding (bins_outstanding)
  );

  // The bin receiver stalls at random, or for a long stretch on request.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_cycles   <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_beat(input logic cmd, input logic [15:0] re, input logic [15:0] im);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) begin
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {im, re};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
  endtask

  function automatic logic [15:0] pick_sample();
    unique case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_random();
    send_beat(CMD_LOAD, pick_sample(), pick_sample());
  endtask

  task automatic read_bin();
    send_beat(CMD_READ, 16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (bins_outstanding == 0);
    repeat (3 * (1 << size_bits) * size_bits + 40) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [3:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    size_bits = (value < 1) ? 1 : (value > LOG_MAX) ? LOG_MAX : value;
  endtask

  initial begin
    int n, budget, kind, cnt;
    int sizes[8] = '{2, 3, 4, 5, 6, 1, 8, 3};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A partial frame at the reset size gives no result yet.
    read_bin();
    repeat (12) load_random();
    read_bin();

    // Directed beats at the smallest frame size.
    write_size(4'd0);
    send_beat(CMD_LOAD, 16'h7FFF, 16'h7FFF);
    send_beat(CMD_LOAD, 16'h8000, 16'h8000);
    repeat (3) read_bin();
    send_beat(CMD_LOAD, 16'h8000, 16'h7FFF);
    read_bin();
    send_beat(CMD_LOAD, 16'h7FFF, 16'h8000);
    repeat (2) read_bin();
    write_size(4'd1);
    send_beat(CMD_LOAD, 16'h0000, 16'hFFFF);
    send_beat(CMD_LOAD, 16'hFFFF, 16'h0000);
    repeat (2) read_bin();

    // A size above the largest is used as the largest.
    write_size(4'd15);
    repeat (12) load_random();
    read_bin();

    for (int phase = 0; phase < 8; phase++) begin
      unique case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      write_size(4'(sizes[phase]));
      n = 1 << size_bits;
      budget = PHASE_BEATS;
      while (budget > 0) begin
        kind = $urandom_range(9);
        if (kind < 8) begin
          repeat (n) load_random();
          cnt = $urandom_range(n + 3);
          if (phase == 0 && budget == PHASE_BEATS) begin
            hold_req++;
            cnt = 2 * n + 12;
          end
          repeat (cnt) read_bin();
          if (phase == 1 && kind == 0) begin
            s_axis_tvalid <= 1'b0;
            wait (bins_outstanding == 0);
          end
          budget -= n + cnt;
        end else if (kind == 8) begin
          cnt = $urandom_range(n - 1);
          repeat (cnt) load_random();
          repeat (2) read_bin();
          budget -= cnt + 2;
        end else begin
          repeat (6) begin
            if ($urandom_range(1)) begin
              read_bin();
            end else begin
              load_random();
            end
          end
          budget -= 6;
        end
      end
    end

    idle_pct = 0;
    stall_pct = 0;
    drain();
    if (mismatch_count == 0 && bins_outstanding == 0) begin
      $display("radix2_fft_in_place regression: pass");
    end else begin
      $display("radix2_fft_in_place regression: fail");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("radix2_fft_in_place regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/r2fft_pkg.sv
hdl/r2fft_ram.sv
hdl/r2fft_ctrl.sv
hdl/r2fft_dp.sv
hdl/radix2_fft_in_place.sv
tb/sv/radix2_fft_in_place_checker.sv
tb/sv/radix2_fft_in_place_tb.sv
